// ----- rtl/pra_pkg.sv -----
// pra_pkg: shared types, constants and register indexes of the pedal range autocalibrator
// depends on nothing; used by every rtl file of the block but pra_ram
`timescale 1ns / 1ps
package pra_pkg;

    // widths of the item and register fields
    localparam int SAMPLE_W   = 10;
    localparam int MARGIN_W   = 8;
    localparam int OVERRIDE_W = 11;
    localparam int BOUND_W    = 12;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 11;

    // default ring depth
    localparam int HISTORY_DEPTH_DEF = 8;

    // quotient bits produced by each serial divide
    localparam int DIV_STEPS = 10;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MARGIN    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CAL_EN    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_CHG_DIV   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_OVERRIDE  = 3'd4;

    // register reset values
    localparam logic [SAMPLE_W-1:0]   THRESHOLD_RST = 10'd16;
    localparam logic [MARGIN_W-1:0]   MARGIN_RST    = 8'd8;
    localparam logic                  CAL_EN_RST    = 1'b1;
    localparam logic [SAMPLE_W-1:0]   CHG_DIV_RST   = 10'd1;
    localparam logic [OVERRIDE_W-1:0] OVERRIDE_RST  = 11'h7FF;

    // bound and scan constants
    localparam logic signed [BOUND_W-1:0] LOW_BOUND_RST  = 12'sd1024;
    localparam logic signed [BOUND_W-1:0] HIGH_BOUND_RST = -12'sd1;
    localparam logic signed [BOUND_W-1:0] SCAN_TOP_INIT  = -12'sd1;
    localparam logic signed [BOUND_W-1:0] SCAN_BOT_INIT  = 12'sd1024;
    localparam logic [SAMPLE_W-1:0]       POS_MAX        = 10'd1023;
    localparam logic [SAMPLE_W-1:0]       DIV_ONE        = 10'd1;

    typedef struct packed {
        logic [SAMPLE_W-1:0]   threshold;
        logic [MARGIN_W-1:0]   margin;
        logic                  calibrate_enable;
        logic [SAMPLE_W-1:0]   change_divider;
        logic [OVERRIDE_W-1:0] override_value;
    } t_cfg;

    // classified item passed from front to back
    typedef struct packed {
        logic [SAMPLE_W-1:0] value;
        logic                present;    // above threshold, enters the ring
        logic                qualifies;  // runs the bound update
    } t_item;

    typedef struct packed {
        logic [SAMPLE_W-1:0] scaled_position;
        logic [SAMPLE_W-1:0] held_sample;
        logic                is_calibrated;
        logic                position_changed;
    } t_result;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_BOUND,
        ST_PREP,
        ST_DIV,
        ST_QDIV,
        ST_DONE
    } t_state;

endpackage

// ----- rtl/pra_ram.sv -----
// pra_ram: generic single write port, single read port ram with registered read
// depends on nothing
`timescale 1ns / 1ps
module pra_ram #(
    parameter int WIDTH = 10,
    parameter int DEPTH = 8
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/pra_front.sv -----
// pra_front: input handshake, override selection and threshold classification
// depends on pra_pkg
`timescale 1ns / 1ps
module pra_front (
    input  logic                          i_in_valid,
    input  logic [pra_pkg::SAMPLE_W-1:0]  i_sample,
    output logic                          o_in_ready,
    input  pra_pkg::t_cfg                 i_cfg,
    input  logic                          i_full,
    output logic                          o_push,
    output pra_pkg::t_item                o_item
);

    logic [pra_pkg::SAMPLE_W-1:0] held;

    // override replaces the sample while its sign bit is clear
    always_comb begin
        if (!i_cfg.override_value[pra_pkg::OVERRIDE_W-1]) begin
            held = i_cfg.override_value[pra_pkg::SAMPLE_W-1:0];
        end else begin
            held = i_sample;
        end
    end

    // classify against the threshold
    always_comb begin
        o_item.value     = held;
        o_item.present   = held > i_cfg.threshold;
        o_item.qualifies = i_cfg.calibrate_enable && (held >= i_cfg.threshold);
    end

    assign o_in_ready = !i_full;
    assign o_push     = i_in_valid && !i_full;

endmodule

// ----- rtl/pra_queue.sv -----
// pra_queue: two entry queue of classified items between front and back
// depends on pra_pkg
`timescale 1ns / 1ps
module pra_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  pra_pkg::t_item i_item,
    output logic           o_full,
    input  logic           i_pop,
    output logic           o_valid,
    output pra_pkg::t_item o_item
);

    pra_pkg::t_item r_slot [2];
    logic           r_wp;
    logic           r_rp;
    logic [1:0]     r_count;

    // entry storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wp] <= i_item;
        end
    end

    // pointers and occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= 1'b0;
            r_rp    <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (i_push) begin
                r_wp <= !r_wp;
            end
            if (i_pop) begin
                r_rp <= !r_rp;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 2'd1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 2'd1;
            end
        end
    end

    assign o_full  = r_count == 2'd2;
    assign o_valid = r_count != 2'd0;
    assign o_item  = r_slot[r_rp];

endmodule

// ----- rtl/pra_back.sv -----
// pra_back: ring update, bound scan, serial scaling divide and change detection
// depends on pra_pkg and pra_ram
`timescale 1ns / 1ps
module pra_back #(
    parameter int HISTORY_DEPTH = pra_pkg::HISTORY_DEPTH_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  pra_pkg::t_cfg        i_cfg,
    input  logic                 i_valid,
    input  pra_pkg::t_item       i_item,
    output logic                 o_pop,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output pra_pkg::t_result     o_result
);

    localparam int AW = $clog2(HISTORY_DEPTH);
    localparam int CW = $clog2(HISTORY_DEPTH + 1);
    localparam logic [CW-1:0] DEPTH_C = CW'(HISTORY_DEPTH);
    localparam logic [AW-1:0] LAST_SLOT = AW'(HISTORY_DEPTH - 1);
    localparam logic [pra_pkg::DIV_CNT_W-1:0] STEP_LAST =
        pra_pkg::DIV_CNT_W'(pra_pkg::DIV_STEPS - 1);
    localparam int SW = pra_pkg::SAMPLE_W;
    localparam int BW = pra_pkg::BOUND_W;

    pra_pkg::t_state r_state, n_state;

    pra_pkg::t_item          r_item,     n_item;
    logic [AW-1:0]           r_slot,     n_slot;
    logic [CW-1:0]           r_fill,     n_fill;
    logic [CW-1:0]           r_idx,      n_idx;
    logic                    r_pend_ok,  n_pend_ok;
    logic signed [BW-1:0]    r_top,      n_top;
    logic signed [BW-1:0]    r_bottom,   n_bottom;
    logic signed [BW-1:0]    r_low,      n_low;
    logic signed [BW-1:0]    r_high,     n_high;
    logic [BW-1:0]           r_rem,      n_rem;
    logic [BW-1:0]           r_den,      n_den;
    logic [SW-1:0]           r_quo,      n_quo;
    logic [SW-1:0]           r_scaled,   n_scaled;
    logic [pra_pkg::DIV_CNT_W-1:0] r_cnt, n_cnt;
    logic [SW-1:0]           r_da,       n_da;
    logic [SW-1:0]           r_db,       n_db;
    logic [SW-1:0]           r_ra,       n_ra;
    logic [SW-1:0]           r_rb,       n_rb;
    logic [SW-1:0]           r_last,     n_last;
    pra_pkg::t_result        r_out,      n_out;
    logic                    r_out_valid, n_out_valid;

    logic                    ram_we;
    logic [SW-1:0]           ram_rdata;
    logic                    out_free;
    logic                    div_last;

    // scan and divide helpers
    logic signed [BW-1:0]    hist_s;
    logic signed [BW-1:0]    sample_s;
    logic signed [BW-1:0]    margin_s;
    logic signed [BW-1:0]    cand_low;
    logic signed [BW-1:0]    cand_high;
    logic [BW:0]             rem_sh;
    logic                    rem_bit;
    logic [SW-1:0]           divisor;
    logic [SW:0]             qa_sh;
    logic [SW:0]             qb_sh;
    logic                    qa_bit;
    logic                    qb_bit;

    // ring of recent samples
    pra_ram #(
        .WIDTH(SW),
        .DEPTH(HISTORY_DEPTH)
    ) u_hist (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_slot),
        .i_wdata (i_item.value),
        .i_raddr (r_idx[AW-1:0]),
        .o_rdata (ram_rdata)
    );

    assign o_pop    = (r_state == pra_pkg::ST_IDLE) && i_valid;
    assign ram_we   = o_pop && i_item.present;
    assign out_free = !r_out_valid || i_out_ready;
    assign div_last = r_cnt == STEP_LAST;

    assign hist_s    = $signed({{(BW - SW){1'b0}}, ram_rdata});
    assign sample_s  = $signed({{(BW - SW){1'b0}}, r_item.value});
    assign margin_s  = $signed({{(BW - pra_pkg::MARGIN_W){1'b0}}, i_cfg.margin});
    assign cand_low  = r_top + margin_s;
    assign cand_high = r_bottom - margin_s;

    // one step of the scaling divide
    assign rem_sh  = {r_rem, 1'b0};
    assign rem_bit = rem_sh >= {1'b0, r_den};

    // one step of both quantizing divides
    assign divisor = (i_cfg.change_divider == '0) ? pra_pkg::DIV_ONE : i_cfg.change_divider;
    assign qa_sh   = {r_ra, r_da[SW-1]};
    assign qb_sh   = {r_rb, r_db[SW-1]};
    assign qa_bit  = qa_sh >= {1'b0, divisor};
    assign qb_bit  = qb_sh >= {1'b0, divisor};

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            pra_pkg::ST_IDLE: begin
                if (i_valid) begin
                    n_state = pra_pkg::ST_SCAN;
                end
            end
            pra_pkg::ST_SCAN: begin
                if (r_idx == DEPTH_C) begin
                    n_state = pra_pkg::ST_BOUND;
                end
            end
            pra_pkg::ST_BOUND: n_state = pra_pkg::ST_PREP;
            pra_pkg::ST_PREP: begin
                if ((r_high > r_low) && (sample_s > r_low) && (sample_s < r_high)) begin
                    n_state = pra_pkg::ST_DIV;
                end else begin
                    n_state = pra_pkg::ST_QDIV;
                end
            end
            pra_pkg::ST_DIV: begin
                if (div_last) begin
                    n_state = pra_pkg::ST_QDIV;
                end
            end
            pra_pkg::ST_QDIV: begin
                if (div_last) begin
                    n_state = pra_pkg::ST_DONE;
                end
            end
            pra_pkg::ST_DONE: begin
                if (out_free) begin
                    n_state = pra_pkg::ST_IDLE;
                end
            end
            default: n_state = pra_pkg::ST_IDLE;
        endcase
    end

    // datapath per state
    always_comb begin
        n_item      = r_item;
        n_slot      = r_slot;
        n_fill      = r_fill;
        n_idx       = r_idx;
        n_pend_ok   = r_pend_ok;
        n_top       = r_top;
        n_bottom    = r_bottom;
        n_low       = r_low;
        n_high      = r_high;
        n_rem       = r_rem;
        n_den       = r_den;
        n_quo       = r_quo;
        n_scaled    = r_scaled;
        n_cnt       = r_cnt;
        n_da        = r_da;
        n_db        = r_db;
        n_ra        = r_ra;
        n_rb        = r_rb;
        n_last      = r_last;
        n_out       = r_out;
        n_out_valid = r_out_valid && !i_out_ready;
        case (r_state)
            pra_pkg::ST_IDLE: begin
                // take the item, write the ring, start the scan
                if (i_valid) begin
                    n_item    = i_item;
                    n_idx     = '0;
                    n_pend_ok = 1'b0;
                    n_top     = pra_pkg::SCAN_TOP_INIT;
                    n_bottom  = pra_pkg::SCAN_BOT_INIT;
                    if (i_item.present) begin
                        n_slot = (r_slot == LAST_SLOT) ? '0 : r_slot + 1'b1;
                        if (r_fill != DEPTH_C) begin
                            n_fill = r_fill + 1'b1;
                        end
                    end
                end
            end
            pra_pkg::ST_SCAN: begin
                // read data is registered, so it belongs to the previous address
                if (r_pend_ok && (ram_rdata > i_cfg.threshold)) begin
                    if (hist_s > r_top) begin
                        n_top = hist_s;
                    end
                    if (hist_s < r_bottom) begin
                        n_bottom = hist_s;
                    end
                end
                if (r_idx != DEPTH_C) begin
                    n_pend_ok = r_idx < r_fill;
                    n_idx     = r_idx + 1'b1;
                end
            end
            pra_pkg::ST_BOUND: begin
                if (r_item.qualifies) begin
                    if (cand_low < r_low) begin
                        n_low = cand_low;
                    end
                    if (cand_high > r_high) begin
                        n_high = cand_high;
                    end
                end
            end
            pra_pkg::ST_PREP: begin
                // clamp cases skip the scaling divide
                n_cnt = '0;
                n_rem = $unsigned(sample_s - r_low);
                n_den = $unsigned(r_high - r_low);
                if (!(r_high > r_low) || (sample_s <= r_low)) begin
                    n_scaled = '0;
                end else begin
                    n_scaled = pra_pkg::POS_MAX;
                end
                n_da = r_last;
                n_db = n_scaled;
                n_ra = '0;
                n_rb = '0;
            end
            pra_pkg::ST_DIV: begin
                // fraction bits of (v - low) / (high - low)
                n_rem = rem_bit ? BW'(rem_sh - {1'b0, r_den}) : rem_sh[BW-1:0];
                n_quo = {r_quo[SW-2:0], rem_bit};
                n_cnt = r_cnt + 1'b1;
                if (div_last) begin
                    n_cnt    = '0;
                    n_scaled = {r_quo[SW-2:0], rem_bit};
                    n_da     = r_last;
                    n_db     = {r_quo[SW-2:0], rem_bit};
                    n_ra     = '0;
                    n_rb     = '0;
                end
            end
            pra_pkg::ST_QDIV: begin
                // last reported and new position divided side by side
                n_ra  = qa_bit ? SW'(qa_sh - {1'b0, divisor}) : qa_sh[SW-1:0];
                n_rb  = qb_bit ? SW'(qb_sh - {1'b0, divisor}) : qb_sh[SW-1:0];
                n_da  = {r_da[SW-2:0], qa_bit};
                n_db  = {r_db[SW-2:0], qb_bit};
                n_cnt = r_cnt + 1'b1;
            end
            pra_pkg::ST_DONE: begin
                // hand the result to the output register
                if (out_free) begin
                    n_out.scaled_position  = r_scaled;
                    n_out.held_sample      = r_item.value;
                    n_out.is_calibrated    = r_low < r_high;
                    n_out.position_changed = r_da != r_db;
                    n_out_valid            = 1'b1;
                    if (r_da != r_db) begin
                        n_last = r_scaled;
                    end
                end
            end
            default: ;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= pra_pkg::ST_IDLE;
            r_slot      <= '0;
            r_fill      <= '0;
            r_low       <= pra_pkg::LOW_BOUND_RST;
            r_high      <= pra_pkg::HIGH_BOUND_RST;
            r_last      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_slot      <= n_slot;
            r_fill      <= n_fill;
            r_low       <= n_low;
            r_high      <= n_high;
            r_last      <= n_last;
            r_out_valid <= n_out_valid;
        end
    end

    // working registers
    always_ff @(posedge i_clk) begin
        r_item    <= n_item;
        r_idx     <= n_idx;
        r_pend_ok <= n_pend_ok;
        r_top     <= n_top;
        r_bottom  <= n_bottom;
        r_rem     <= n_rem;
        r_den     <= n_den;
        r_quo     <= n_quo;
        r_scaled  <= n_scaled;
        r_cnt     <= n_cnt;
        r_da      <= n_da;
        r_db      <= n_db;
        r_ra      <= n_ra;
        r_rb      <= n_rb;
        r_out     <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_result    = r_out;

endmodule

// ----- rtl/pedal_range_autocalibrator.sv -----
// pedal_range_autocalibrator: top level with configuration registers, front, queue and back
// depends on pra_pkg, pra_front, pra_queue, pra_back
`timescale 1ns / 1ps
// Usage
// - input channel: i_in_valid / o_in_ready carry one 10-bit sample per item
// - output channel: o_out_valid / i_out_ready carry one result per item:
//   scaled position, held sample, calibrated flag and changed flag
// - configuration: i_cfg_we writes i_cfg_data into register i_cfg_idx
//   (0 threshold, 1 margin, 2 calibrate enable, 3 change divider,
//   4 override value); write only while no item is in flight
// - the back end takes a new item only after it is through with the last one:
//   one ram read per ring entry for the bound scan, then the 10-step scaling
//   divide (skipped when the position clamps) and the 10-step quantizing
//   divides, all sharing one step counter
// - a two entry queue lets the input side accept items while the back end works
// - reset (synchronous, active low) clears the ring fill count, bounds,
//   last reported position, queue and output valid; registers take defaults
// - while the receiver stalls the result holds in the output register; the
//   back end then waits and the queue absorbs up to two more items
module pedal_range_autocalibrator #(
    parameter int HISTORY_DEPTH = pra_pkg::HISTORY_DEPTH_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  logic [pra_pkg::SAMPLE_W-1:0]     i_sample,
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output logic [pra_pkg::SAMPLE_W-1:0]     o_scaled_position,
    output logic [pra_pkg::SAMPLE_W-1:0]     o_held_sample,
    output logic                             o_is_calibrated,
    output logic                             o_position_changed,
    input  logic                             i_cfg_we,
    input  logic [pra_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [pra_pkg::CFG_DATA_W-1:0]   i_cfg_data
);

    pra_pkg::t_cfg    r_cfg;
    pra_pkg::t_item   push_item;
    pra_pkg::t_item   head_item;
    pra_pkg::t_result result;
    logic             push;
    logic             full;
    logic             head_valid;
    logic             pop;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.threshold        <= pra_pkg::THRESHOLD_RST;
            r_cfg.margin           <= pra_pkg::MARGIN_RST;
            r_cfg.calibrate_enable <= pra_pkg::CAL_EN_RST;
            r_cfg.change_divider   <= pra_pkg::CHG_DIV_RST;
            r_cfg.override_value   <= pra_pkg::OVERRIDE_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                pra_pkg::REG_THRESHOLD: r_cfg.threshold <= i_cfg_data[pra_pkg::SAMPLE_W-1:0];
                pra_pkg::REG_MARGIN:    r_cfg.margin    <= i_cfg_data[pra_pkg::MARGIN_W-1:0];
                pra_pkg::REG_CAL_EN:    r_cfg.calibrate_enable <= i_cfg_data[0];
                pra_pkg::REG_CHG_DIV:
                    r_cfg.change_divider <= i_cfg_data[pra_pkg::SAMPLE_W-1:0];
                pra_pkg::REG_OVERRIDE:  r_cfg.override_value <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // front: accept and classify
    pra_front u_front (
        .i_in_valid (i_in_valid),
        .i_sample   (i_sample),
        .o_in_ready (o_in_ready),
        .i_cfg      (r_cfg),
        .i_full     (full),
        .o_push     (push),
        .o_item     (push_item)
    );

    // queue between front and back
    pra_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (push_item),
        .o_full  (full),
        .i_pop   (pop),
        .o_valid (head_valid),
        .o_item  (head_item)
    );

    // back: calibration and scaling
    pra_back #(
        .HISTORY_DEPTH(HISTORY_DEPTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_valid     (head_valid),
        .i_item      (head_item),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_result    (result)
    );

    assign o_scaled_position  = result.scaled_position;
    assign o_held_sample      = result.held_sample;
    assign o_is_calibrated    = result.is_calibrated;
    assign o_position_changed = result.position_changed;

endmodule

// ----- rtl/pra_checker.sv -----
// pra_checker: port level assertions for the pedal range autocalibrator, bound to the top
// depends on pra_pkg and pedal_range_autocalibrator
`timescale 1ns / 1ps
module pra_checker (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         i_in_valid,
    input logic                         o_in_ready,
    input logic                         o_out_valid,
    input logic                         i_out_ready,
    input logic [pra_pkg::SAMPLE_W-1:0] o_scaled_position,
    input logic [pra_pkg::SAMPLE_W-1:0] o_held_sample,
    input logic                         o_is_calibrated,
    input logic                         o_position_changed
);

    // a stalled result holds until taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_scaled_position)
            && $stable(o_held_sample) && $stable(o_position_changed))
        else $error("stalled result changed");

    // without valid bounds the position reads zero
    a_uncal_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_is_calibrated |-> o_scaled_position == '0)
        else $error("position nonzero while not calibrated");

    // reset empties the output register
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    // a waiting input item stays offered until taken
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_ready |=> i_in_valid)
        else $error("input item withdrawn before accept");

    // a valid result carries no unknown bits
    a_out_known: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !$isunknown({o_scaled_position, o_held_sample,
                                     o_is_calibrated, o_position_changed}))
        else $error("unknown bits in result");

endmodule

bind pedal_range_autocalibrator pra_checker u_pra_checker (
    .i_clk              (i_clk),
    .i_rst_n            (i_rst_n),
    .i_in_valid         (i_in_valid),
    .o_in_ready         (o_in_ready),
    .o_out_valid        (o_out_valid),
    .i_out_ready        (i_out_ready),
    .o_scaled_position  (o_scaled_position),
    .o_held_sample      (o_held_sample),
    .o_is_calibrated    (o_is_calibrated),
    .o_position_changed (o_position_changed)
);
